// ===== src/kct_pkg.sv =====
package kct_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FIELD_BITS  = 16;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_ZERO     = 3'd1,
    STAT_ABSENT   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    op_e                   op;
    logic                  amt_zero;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] amount;
  } req_t;

endpackage

// ===== src/kct_front.sv =====
module kct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,  // item_key, amount
  input  logic [1:0]    s_axis_tuser,  // req_type
  output logic          req_valid_o,
  output kct_pkg::req_t req_o,
  input  logic          req_pop_i
);
  import kct_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  req_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] fill_q, fill_d;
  req_t          cls;
  logic          push;
  logic          pop;

  // classify the incoming transfer
  always_comb begin
    cls.key      = s_axis_tdata[15:0];
    cls.amount   = s_axis_tdata[31:16];
    cls.amt_zero = (s_axis_tdata[31:16] == '0);
    case (op_e'(s_axis_tuser))
      OP_ADD: begin
        cls.op = OP_ADD;
      end
      OP_REMOVE: begin
        cls.op = OP_REMOVE;
      end
      default: begin
        cls.op = OP_QUERY;
      end
    endcase
  end

  assign s_axis_tready = (fill_q != CW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (fill_q != '0);
  assign pop           = req_pop_i && req_valid_o;
  assign req_o         = queue_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10: begin
        fill_d = fill_q + 1'b1;
      end
      2'b01: begin
        fill_d = fill_q - 1'b1;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= cls;
    end
  end

endmodule

// ===== src/kct_back.sv =====
module kct_back #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  kct_pkg::req_t req_i,
  output logic          req_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata,  // count_now
  output logic [2:0]    m_axis_tuser   // status
);
  import kct_pkg::*;

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KIW = (KEY_BITS > FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam int unsigned AW  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
  localparam int unsigned SW  = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e                st_q, st_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IW-1:0]         chk_idx_q, chk_idx_d;
  logic [IW-1:0]         rd_idx;
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  req_t                  req_q;
  logic                  hit_q;
  logic [IW-1:0]         hit_idx_q;
  logic [COUNT_BITS-1:0] held_q;
  logic                  free_q;
  logic [IW-1:0]         free_idx_q;
  logic                  used_q [ENTRIES];
  logic                  out_vld_q;
  status_e               out_stat_q, res_stat;
  logic [15:0]           out_cnt_q;
  logic                  start;
  logic                  wr_go;
  logic [KIW-1:0]        key_ext;
  logic [KEY_BITS-1:0]   key_m;
  logic [AW-1:0]         held_ext;
  logic [AW-1:0]         amt_ext;
  logic [SW-1:0]         sum;
  logic [AW-1:0]         diff;
  logic                  ovf;
  logic [AW-1:0]         res_held;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  set_used;
  logic                  clr_used;

  assign key_ext = KIW'(req_q.key);
  assign key_m   = key_ext[KEY_BITS-1:0];

  assign start     = (st_q == S_IDLE) && req_valid_i;
  assign req_pop_o = start;
  assign wr_go     = (st_q == S_WRITE) && (!out_vld_q || m_axis_tready);
  assign rd_idx    = (st_q == S_SCAN) ? idx_q : '0;

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          chk_vld_d = 1'b1;
          chk_idx_d = '0;
          idx_d     = IW'(1);
          st_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        if (idx_q == IW'(ENTRIES - 1)) begin
          st_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        st_d = S_WRITE;
      end
      S_WRITE: begin
        if (wr_go) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      if (start) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (chk_vld_q) begin
        if (used_q[chk_idx_q] && (rd_key_q == key_m) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!used_q[chk_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q <= req_i;
    end
    if (chk_vld_q && !start) begin
      if (used_q[chk_idx_q] && (rd_key_q == key_m) && !hit_q) begin
        hit_idx_q <= chk_idx_q;
        held_q    <= rd_cnt_q;
      end
      if (!used_q[chk_idx_q] && !free_q) begin
        free_idx_q <= chk_idx_q;
      end
    end
  end

  // slot store, one read port walked by the scan
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_idx];
    rd_cnt_q <= cnt_mem[rd_idx];
    if (wr_en) begin
      key_mem[wr_idx] <= key_m;
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  assign held_ext = hit_q ? AW'(held_q) : '0;
  assign amt_ext  = AW'(req_q.amount);
  assign sum      = {1'b0, held_ext} + {1'b0, amt_ext};
  assign diff     = held_ext - amt_ext;
  assign ovf      = |sum[SW-1:COUNT_BITS];

  always_comb begin
    res_stat = STAT_DONE;
    res_held = held_ext;
    wr_en    = 1'b0;
    wr_idx   = hit_idx_q;
    wr_cnt   = sum[COUNT_BITS-1:0];
    set_used = 1'b0;
    clr_used = 1'b0;
    case (req_q.op)
      OP_ADD: begin
        if (req_q.amt_zero) begin
          res_stat = STAT_ZERO;
        end else if (ovf) begin
          res_stat = STAT_OVERFLOW;
        end else if (hit_q) begin
          res_held = sum[AW-1:0];
          wr_en    = wr_go;
        end else if (free_q) begin
          res_held = amt_ext;
          wr_en    = wr_go;
          wr_idx   = free_idx_q;
          set_used = 1'b1;
        end else begin
          res_stat = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (req_q.amt_zero) begin
          res_stat = STAT_ZERO;
        end else if (!hit_q || (held_ext < amt_ext)) begin
          res_stat = STAT_ABSENT;
        end else begin
          res_held = diff;
          wr_en    = wr_go;
          wr_cnt   = diff[COUNT_BITS-1:0];
          clr_used = (diff == '0);
        end
      end
      default: begin
        res_stat = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        used_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en && set_used) begin
        used_q[wr_idx] <= 1'b1;
      end else if (wr_en && clr_used) begin
        used_q[wr_idx] <= 1'b0;
      end
      if (wr_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      out_stat_q <= res_stat;
      out_cnt_q  <= res_held[15:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_cnt_q;
  assign m_axis_tuser  = out_stat_q;

`ifndef NO_ASSERTIONS
  a_result_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go |=> out_vld_q)
    else $error("result register not loaded after write back");

  a_new_slot_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && set_used) |-> !used_q[wr_idx])
    else $error("new key placed in an occupied slot");

  a_check_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (st_q == S_SCAN || st_q == S_DRAIN))
    else $error("slot check outside the walk");

  a_full_reports_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && res_stat == STAT_FULL) |=> (m_axis_tdata == '0))
    else $error("full table result carries a count");
`endif

endmodule

// ===== src/keyed_count_table_core.sv =====
// keyed count table: ENTRIES slots of key and count; each transfer is a query, add or
// remove (tuser 0, 1, 2; code 3 acts as a query) and yields one result of status and
// the key's count after the step. a request is held in a two-deep queue and then walks
// every slot through the single read port of the slot store, one slot per cycle, and
// requests are served one at a time in arrival order. adds take the lowest free slot,
// a remove that reaches zero frees its slot, and refused requests leave the table as
// is. the table is empty right after reset, with no clearing pass.
module keyed_count_table_core #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // item_key, amount
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // count_now
  output logic [2:0]  m_axis_tuser   // status
);
  import kct_pkg::*;

  logic req_valid;
  req_t req;
  logic req_pop;

  kct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  kct_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== verif/kct_reply_checker.sv =====
`timescale 1ns / 1ps

module kct_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // item_key, amount
  input  logic [1:0]  s_axis_tuser,  // req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // count_now
  input  logic [2:0]  m_axis_tuser,  // status
  output int          pending_o,
  output int          fail_count_o
);
  import kct_pkg::*;

  localparam int unsigned SLOTS = 16;

  typedef struct packed {
    status_e     status;
    logic [15:0] count_now;
  } reply_t;

  logic        occupied [SLOTS];
  logic [15:0] tag      [SLOTS];
  logic [15:0] tally    [SLOTS];
  reply_t      expected_replies [$];

  task automatic update_table(input logic [1:0] kind, input logic [15:0] key,
                              input logic [15:0] amt, output reply_t reply);
    int          hit;
    int          free_slot;
    logic [16:0] held;
    logic [16:0] sum;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (occupied[i] && tag[i] == key && hit < 0) hit = i;
      if (!occupied[i] && free_slot < 0) free_slot = i;
    end
    held = (hit >= 0) ? {1'b0, tally[hit]} : 17'd0;
    sum  = held + {1'b0, amt};
    reply.status = STAT_DONE;
    if (kind == OP_ADD) begin
      if (amt == 16'd0) begin
        reply.status = STAT_ZERO;
      end else if (sum[16]) begin
        reply.status = STAT_OVERFLOW;
      end else if (hit >= 0) begin
        held       = sum;
        tally[hit] = sum[15:0];
      end else if (free_slot < 0) begin
        reply.status = STAT_FULL;
      end else begin
        occupied[free_slot] = 1'b1;
        tag[free_slot]      = key;
        tally[free_slot]    = amt;
        held                = {1'b0, amt};
      end
    end else if (kind == OP_REMOVE) begin
      if (amt == 16'd0) begin
        reply.status = STAT_ZERO;
      end else if (hit < 0 || held < {1'b0, amt}) begin
        reply.status = STAT_ABSENT;
      end else begin
        held       = held - {1'b0, amt};
        tally[hit] = held[15:0];
        if (held == 17'd0) occupied[hit] = 1'b0;
      end
    end
    reply.count_now = held[15:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
      expected_replies.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        update_table(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16], want);
        expected_replies.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d count %0d",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata !== want.count_now) begin
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count_now, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

// ===== verif/tb_keyed_count_table_core.sv =====
`timescale 1ns / 1ps

module tb_keyed_count_table_core;
  import kct_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // item_key, amount
  logic [1:0]  s_axis_tuser;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // count_now
  logic [2:0]  m_axis_tuser;  // status

  int pending;
  int fail_count;
  bit quiet;

  keyed_count_table_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  kct_reply_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entered after the previous transfer edge, returns at the transfer edge
  task automatic send_item(input logic [1:0] kind, input logic [15:0] key,
                           input logic [15:0] amt);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {amt, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_random();
    int          r;
    int          idx;
    logic [1:0]  kind;
    logic [15:0] key;
    logic [15:0] amt;
    r = $urandom_range(0, 99);
    if (r < 10) kind = OP_QUERY;
    else if (r < 55) kind = OP_ADD;
    else if (r < 95) kind = OP_REMOVE;
    else kind = OP_SPARE;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      idx = $urandom_range(0, 19);
      if (idx == 18) key = 16'h0000;
      else if (idx == 19) key = 16'hffff;
      else key = 16'h0100 + idx[15:0];
    end else begin
      key = 16'($urandom_range(0, 65535));
    end
    r = $urandom_range(0, 99);
    if (r < 5) amt = 16'd0;
    else if (r < 70) amt = 16'($urandom_range(1, 8));
    else if (r < 85) amt = 16'($urandom_range(1, 300));
    else if (r < 92) amt = 16'($urandom_range(16'hff00, 16'hffff));
    else amt = 16'($urandom_range(0, 65535));
    send_item(kind, key, amt);
  endtask

  // result side: random stalls; in quiet stretches only ready is drawn
  initial begin : sink
    int  sink_left;
    bit  ready_n;
    m_axis_tready = 1'b0;
    sink_left     = 0;
    forever begin
      @(negedge clk_i);
      if (sink_left > 0) begin
        sink_left--;
      end else begin
        ready_n = quiet || ($urandom_range(0, 2) != 0);
        m_axis_tready <= ready_n;
        sink_left = ready_n ? $urandom_range(0, 8) : pick_gap();
      end
    end
  end

  initial begin
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_QUERY;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    send_item(OP_QUERY,  16'h0000, 16'h0000);
    send_item(OP_ADD,    16'h0005, 16'h0000);
    send_item(OP_REMOVE, 16'h0005, 16'h0000);
    send_item(OP_REMOVE, 16'h0005, 16'h0001);
    send_item(OP_ADD,    16'hffff, 16'hffff);
    send_item(OP_ADD,    16'hffff, 16'h0001);
    send_item(OP_ADD,    16'h0000, 16'h0003);
    send_item(OP_REMOVE, 16'h0000, 16'h0004);
    send_item(OP_SPARE,  16'h0000, 16'h0002);
    send_item(OP_REMOVE, 16'h0000, 16'h0003);
    send_item(OP_QUERY,  16'hffff, 16'hffff);
    // fill the free slots
    for (int i = 0; i < 15; i++) begin
      send_item(OP_ADD, 16'h0100 + 16'(i), 16'h0001 + 16'(i));
    end
    send_item(OP_ADD,    16'h0200, 16'h0001);
    send_item(OP_REMOVE, 16'h0105, 16'h0006);
    send_item(OP_ADD,    16'h0200, 16'h0002);

    // random part
    for (int phase = 0; phase < 5; phase++) begin
      quiet = (phase == 2);
      repeat (105) send_random();
      if (phase == 1 || phase == 3) begin
        idle_sender();
        wait (pending == 0);
      end
    end
    quiet = 1'b0;

    idle_sender();
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("keyed_count_table_core verification clean");
    end else begin
      $display("keyed_count_table_core verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("keyed_count_table_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/kct_pkg.sv
src/kct_front.sv
src/kct_back.sv
src/keyed_count_table_core.sv
verif/kct_reply_checker.sv
verif/tb_keyed_count_table_core.sv
